>>> rtl/core/tvcg_pkg.sv
// ----------------------------------------------------------------------------
// tvcg_pkg: shared types and constants of the two-voice crossfade gain block
// Fixed-point widths, item mode codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tvcg_pkg;

  // gain and progress format, Q1.GAIN_FRAC_BITS
  localparam int GAIN_FRAC_BITS = 15;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);

  // input field widths
  localparam int MODE_W  = 2;
  localparam int DT_W    = 20;
  localparam int SLOPE_W = 24;

  // progress increment: dt * ONE / fade length
  localparam int NUM_W = DT_W + GAIN_FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  // product of two gains
  localparam int PROD_W = 2 * GAIN_W;

  // item modes, the unused code is ignored
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CSQ,
    S_CCUBE,
    S_CK,
    S_APPLY,
    S_GAIN,
    S_FIN
  } state_e;

endpackage

>>> rtl/core/tvcg_div.sv
// ----------------------------------------------------------------------------
// tvcg_div: serial restoring divider
// One quotient bit per cycle, a step for each of the NUM_W dividend bits.
// ----------------------------------------------------------------------------
module tvcg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tvcg_pkg::NUM_W-1:0]   dividend_i,
  input  logic [tvcg_pkg::SLOPE_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [tvcg_pkg::NUM_W-1:0]   quotient_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [tvcg_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [tvcg_pkg::SLOPE_W-1:0] rem_q, rem_d;
  logic [tvcg_pkg::NUM_W-1:0]   nq_q, nq_d;

  logic [tvcg_pkg::SLOPE_W:0]   trial;
  logic [tvcg_pkg::SLOPE_W:0]   diff;
  logic                         ge;

  // trial subtract of one step
  assign trial = {rem_q, nq_q[tvcg_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  // step control, dividend bits leave at the top as quotient bits enter below
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    nq_d   = nq_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tvcg_pkg::CNT_W'(tvcg_pkg::NUM_W - 1);
      rem_d  = '0;
      nq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[tvcg_pkg::SLOPE_W-1:0] : trial[tvcg_pkg::SLOPE_W-1:0];
      nq_d  = {nq_q[tvcg_pkg::NUM_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
  end

  assign done_o     = done_q;
  assign quotient_o = nq_q;

endmodule

>>> rtl/core/two_voice_crossfade_gain_top.sv
// ----------------------------------------------------------------------------
// two_voice_crossfade_gain_top: crossfade controller for two playback voices
// Tracks fade progress, voice roles and gains, one result per item.
// ----------------------------------------------------------------------------
// One input item at a time. A tick that advances a running fade goes through
// the serial divider (one quotient bit per cycle over the 35-bit dt * 1.0
// dividend) and then the curve and the gain multiply; a play that cuts into a
// running fade first takes the curve value of the old fade as its base gain.
// The cubic curve and the outgoing gain go through one shared 16x16
// multiplier, one product per cycle. in_stall_o is high while an item is in
// work; a finished result sits in the output register, so the next item can
// be taken while it waits for its transfer. No clearing pass after reset.
module two_voice_crossfade_gain_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tvcg_pkg::MODE_W-1:0]         mode_i,
  input  logic [tvcg_pkg::DT_W-1:0]           dt_us_i,
  input  logic [tvcg_pkg::SLOPE_W-1:0]        slope_us_i,
  input  logic                                cubic_curve_i,
  input  logic                                pause_on_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                outgoing_voice_o,
  output logic [tvcg_pkg::GAIN_W-1:0]         outgoing_gain_o,
  output logic [tvcg_pkg::GAIN_W-1:0]         incoming_gain_o,
  output logic [1:0]                          stop_mask_o,
  output logic [1:0]                          start_mask_o,
  output logic                                fading_o,
  output logic                                is_paused_o
);

  localparam int GW = tvcg_pkg::GAIN_W;

  // mask bit of a physical voice
  function automatic logic [1:0] voice_bit(input logic v);
    return v ? 2'b10 : 2'b01;
  endfunction

  tvcg_pkg::state_e state_q, state_d;

  // block state
  logic [GW-1:0]                progress_q, progress_d;
  logic [tvcg_pkg::SLOPE_W-1:0] fade_len_q, fade_len_d;
  logic                         use_cubic_q, use_cubic_d;
  logic [GW-1:0]                base_q, base_d;
  logic                         out_voice_q, out_voice_d;
  logic                         paused_q, paused_d;
  logic                         out_loaded_q, out_loaded_d;
  logic                         in_loaded_q, in_loaded_d;

  // item in work
  logic [tvcg_pkg::MODE_W-1:0]  mode_q;
  logic [tvcg_pkg::SLOPE_W-1:0] slope_q;
  logic                         cub_q;
  logic                         pon_q;
  logic                         tick_go_q;
  logic                         pre_q;
  logic [1:0]                   stop_q, stop_d;
  logic [1:0]                   start_q, start_d;

  // shared multiplier and curve value
  logic [GW-1:0]                op_a, op_b;
  logic                         mul_en;
  logic [tvcg_pkg::PROD_W-1:0]  prod_q;
  logic [GW-1:0]                k_q;
  logic [GW-1:0]                prod_hi;

  // output register
  logic                         out_valid_q;
  logic                         res_voice_q;
  logic [GW-1:0]                res_og_q, res_ig_q;
  logic [1:0]                   res_stop_q, res_start_q;
  logic                         res_fading_q, res_paused_q;

  logic                         in_acc;
  logic                         out_free;
  logic                         fading_now;
  logic                         tick_go;
  logic                         pre_go;
  logic [tvcg_pkg::SLOPE_W-1:0] divisor;
  logic                         div_done;
  logic [tvcg_pkg::NUM_W-1:0]   quotient;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fading_now = progress_q < tvcg_pkg::GAIN_ONE;
  assign tick_go    = (mode_i == tvcg_pkg::MODE_TICK) && !paused_q && fading_now;
  assign pre_go     = (mode_i == tvcg_pkg::MODE_PLAY) && (slope_us_i != '0) && fading_now;
  assign divisor    = (fade_len_q == '0) ? tvcg_pkg::SLOPE_W'(1) : fade_len_q;
  assign prod_hi    = prod_q[tvcg_pkg::GAIN_FRAC_BITS +: GW];

  // progress increment divider
  tvcg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && tick_go),
    .dividend_i ({dt_us_i, tvcg_pkg::GAIN_FRAC_BITS'(0)}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // cubic curve terms: x = 2p - 1, a = |x|
  logic [GW:0]   u2p, one_x, a_full, ksum;
  logic          neg;
  logic [GW-1:0] a_mag, k_cubic;

  assign u2p     = {progress_q, 1'b0};
  assign one_x   = {1'b0, tvcg_pkg::GAIN_ONE};
  assign neg     = u2p < one_x;
  assign a_full  = neg ? (one_x - u2p) : (u2p - one_x);
  assign a_mag   = a_full[GW-1:0];
  assign ksum    = neg ? (one_x - {1'b0, prod_hi}) : (one_x + {1'b0, prod_hi});
  assign k_cubic = ksum[GW:1];

  // multiplier operand select
  always_comb begin
    op_a   = a_mag;
    op_b   = a_mag;
    mul_en = 1'b0;
    unique case (state_q)
      tvcg_pkg::S_CSQ: begin
        mul_en = use_cubic_q;
      end
      tvcg_pkg::S_CCUBE: begin
        op_a   = prod_hi;
        mul_en = 1'b1;
      end
      tvcg_pkg::S_GAIN: begin
        op_a   = tvcg_pkg::GAIN_ONE - k_q;
        op_b   = base_q;
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // state update of one item
  always_comb begin
    progress_d   = progress_q;
    fade_len_d   = fade_len_q;
    use_cubic_d  = use_cubic_q;
    base_d       = base_q;
    out_voice_d  = out_voice_q;
    paused_d     = paused_q;
    out_loaded_d = out_loaded_q;
    in_loaded_d  = in_loaded_q;
    stop_d       = 2'b00;
    start_d      = 2'b00;
    priority if (mode_q == tvcg_pkg::MODE_TICK) begin
      if (tick_go_q) begin
        if (quotient >= tvcg_pkg::NUM_W'(tvcg_pkg::GAIN_ONE - progress_q)) begin
          // fade ends
          if (out_loaded_q) stop_d = voice_bit(out_voice_q);
          out_voice_d  = !out_voice_q;
          base_d       = tvcg_pkg::GAIN_ONE;
          out_loaded_d = in_loaded_q;
          in_loaded_d  = 1'b0;
          progress_d   = tvcg_pkg::GAIN_ONE;
        end else begin
          progress_d = progress_q + quotient[GW-1:0];
        end
      end
    end else if (mode_q == tvcg_pkg::MODE_PLAY) begin
      if (slope_q == '0) begin
        // instant switch
        if (out_loaded_q) stop_d = stop_d | voice_bit(out_voice_q);
        if (in_loaded_q)  stop_d = stop_d | voice_bit(!out_voice_q);
        in_loaded_d  = 1'b0;
        out_loaded_d = 1'b1;
        progress_d   = tvcg_pkg::GAIN_ONE;
        base_d       = tvcg_pkg::GAIN_ONE;
        start_d      = voice_bit(out_voice_q);
      end else begin
        if (pre_q) begin
          // cut into a running fade
          if (out_loaded_q) stop_d = voice_bit(out_voice_q);
          base_d       = k_q;
          out_loaded_d = in_loaded_q;
          out_voice_d  = !out_voice_q;
        end else begin
          base_d = tvcg_pkg::GAIN_ONE;
        end
        in_loaded_d = 1'b1;
        progress_d  = '0;
        fade_len_d  = slope_q;
        use_cubic_d = cub_q;
        start_d     = voice_bit(!out_voice_d);
      end
    end else if (mode_q == tvcg_pkg::MODE_PAUSE) begin
      paused_d = pon_q;
    end else begin
      paused_d = paused_q;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tvcg_pkg::S_IDLE: begin
        if (in_acc) begin
          if (tick_go)     state_d = tvcg_pkg::S_DIV;
          else if (pre_go) state_d = tvcg_pkg::S_CSQ;
          else             state_d = tvcg_pkg::S_APPLY;
        end
      end
      tvcg_pkg::S_DIV: begin
        if (div_done) state_d = tvcg_pkg::S_APPLY;
      end
      tvcg_pkg::S_CSQ: begin
        if (use_cubic_q) state_d = tvcg_pkg::S_CCUBE;
        else if (pre_q)  state_d = tvcg_pkg::S_APPLY;
        else             state_d = tvcg_pkg::S_GAIN;
      end
      tvcg_pkg::S_CCUBE: begin
        state_d = tvcg_pkg::S_CK;
      end
      tvcg_pkg::S_CK: begin
        state_d = pre_q ? tvcg_pkg::S_APPLY : tvcg_pkg::S_GAIN;
      end
      tvcg_pkg::S_APPLY: begin
        state_d = (progress_d < tvcg_pkg::GAIN_ONE) ? tvcg_pkg::S_CSQ : tvcg_pkg::S_FIN;
      end
      tvcg_pkg::S_GAIN: begin
        state_d = tvcg_pkg::S_FIN;
      end
      tvcg_pkg::S_FIN: begin
        if (out_free) state_d = tvcg_pkg::S_IDLE;
      end
      default: begin
        state_d = tvcg_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tvcg_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // block state registers, loaded once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      progress_q   <= tvcg_pkg::GAIN_ONE;
      fade_len_q   <= tvcg_pkg::SLOPE_W'(1);
      use_cubic_q  <= 1'b0;
      base_q       <= tvcg_pkg::GAIN_ONE;
      out_voice_q  <= 1'b0;
      paused_q     <= 1'b0;
      out_loaded_q <= 1'b0;
      in_loaded_q  <= 1'b0;
      pre_q        <= 1'b0;
      tick_go_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        pre_q     <= pre_go;
        tick_go_q <= tick_go;
      end
      if (state_q == tvcg_pkg::S_APPLY) begin
        progress_q   <= progress_d;
        fade_len_q   <= fade_len_d;
        use_cubic_q  <= use_cubic_d;
        base_q       <= base_d;
        out_voice_q  <= out_voice_d;
        paused_q     <= paused_d;
        out_loaded_q <= out_loaded_d;
        in_loaded_q  <= in_loaded_d;
        pre_q        <= 1'b0;
      end
    end
  end

  // item payload, product and curve value
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= mode_i;
      slope_q <= slope_us_i;
      cub_q   <= cubic_curve_i;
      pon_q   <= pause_on_i;
    end
    if (state_q == tvcg_pkg::S_APPLY) begin
      stop_q  <= stop_d;
      start_q <= start_d;
    end
    if (mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (state_q == tvcg_pkg::S_CSQ && !use_cubic_q) begin
      k_q <= progress_q;
    end else if (state_q == tvcg_pkg::S_CK) begin
      k_q <= k_cubic;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == tvcg_pkg::S_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == tvcg_pkg::S_FIN && out_free) begin
      res_voice_q  <= out_voice_q;
      res_og_q     <= fading_now ? prod_hi : tvcg_pkg::GAIN_ONE;
      res_ig_q     <= fading_now ? k_q : '0;
      res_stop_q   <= stop_q;
      res_start_q  <= start_q;
      res_fading_q <= fading_now;
      res_paused_q <= paused_q;
    end
  end

  assign in_stall_o       = state_q != tvcg_pkg::S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign outgoing_voice_o = res_voice_q;
  assign outgoing_gain_o  = res_og_q;
  assign incoming_gain_o  = res_ig_q;
  assign stop_mask_o      = res_stop_q;
  assign start_mask_o     = res_start_q;
  assign fading_o         = res_fading_q;
  assign is_paused_o      = res_paused_q;

`ifndef SYNTH
  // progress never passes full scale
  a_progress_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    progress_q <= tvcg_pkg::GAIN_ONE)
    else $error("progress above full scale");

  // the divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == tvcg_pkg::S_DIV)
    else $error("divider done outside divide state");

  // a result with no fade shows full outgoing gain and silent incoming voice
  a_idle_gains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fading_o) |-> (outgoing_gain_o == tvcg_pkg::GAIN_ONE
                                     && incoming_gain_o == '0))
    else $error("gains wrong with no fade running");

  // incoming gain stays within full scale
  a_in_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> incoming_gain_o <= tvcg_pkg::GAIN_ONE)
    else $error("incoming gain above full scale");
`endif

endmodule

>>> bench/two_voice_crossfade_gain_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_voice_crossfade_gain_top_tb: self-checking bench of the crossfade block
// A queue of commands feeds a valid/stall driver, a predictor of the voice
// roles, fade progress and gains computes each result on every input
// transfer, and a monitor checks every output transfer field by field.
// Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module two_voice_crossfade_gain_top_tb;
  import tvcg_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam longint unsigned   UNITY       = 64'd1 << GAIN_FRAC_BITS;
  localparam int                RANDOM_CMDS = 1950;
  localparam int                CYCLE_LIMIT = 1_000_000;
  localparam int                TAIL_CYCLES = 60;
  localparam int                CALM_CMDS   = 150;
  localparam longint unsigned   DT_MAX      = (64'd1 << DT_W) - 1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DT_W-1:0]    dt;
    logic [SLOPE_W-1:0] slope;
    logic               cubic;
    logic               pause_on;
  } cmd_t;

  typedef struct packed {
    logic              voice;
    logic [GAIN_W-1:0] og;
    logic [GAIN_W-1:0] ig;
    logic [1:0]        stop;
    logic [1:0]        start;
    logic              fading;
    logic              paused;
  } gains_t;

  // clock, reset and block inputs, known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic [MODE_W-1:0]  mode_i        = MODE_TICK;
  logic [DT_W-1:0]    dt_us_i       = '0;
  logic [SLOPE_W-1:0] slope_us_i    = '0;
  logic               cubic_curve_i = 1'b0;
  logic               pause_on_i    = 1'b0;
  logic               out_stall_i   = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic               outgoing_voice_o;
  logic [GAIN_W-1:0]  outgoing_gain_o;
  logic [GAIN_W-1:0]  incoming_gain_o;
  logic [1:0]         stop_mask_o;
  logic [1:0]         start_mask_o;
  logic               fading_o;
  logic               is_paused_o;

  two_voice_crossfade_gain_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .dt_us_i          (dt_us_i),
    .slope_us_i       (slope_us_i),
    .cubic_curve_i    (cubic_curve_i),
    .pause_on_i       (pause_on_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .outgoing_voice_o (outgoing_voice_o),
    .outgoing_gain_o  (outgoing_gain_o),
    .incoming_gain_o  (incoming_gain_o),
    .stop_mask_o      (stop_mask_o),
    .start_mask_o     (start_mask_o),
    .fading_o         (fading_o),
    .is_paused_o      (is_paused_o)
  );

  // bench bookkeeping
  cmd_t   cmd_q[$];
  gains_t gains_due_q[$];
  int     acc_cnt     = 0;
  int     checked_cnt = 0;
  int     err_cnt     = 0;
  int     cycle_cnt   = 0;
  int     n_real      = 0;
  int     n_fade_done = 0;
  int     n_fade_cut  = 0;
  int     n_instant   = 0;
  bit     calm        = 1'b0;

  // predicted block state, at reset values
  longint unsigned prog_st       = UNITY;
  longint unsigned fade_len_st   = 1;
  longint unsigned base_st       = UNITY;
  bit              cubic_st      = 1'b0;
  bit              out_voice_st  = 1'b0;
  bit              paused_st     = 1'b0;
  bit              out_loaded_st = 1'b0;
  bit              in_loaded_st  = 1'b0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // linear or cubic fade curve, q1.15
  function automatic longint unsigned fade_curve(longint unsigned p, bit cub);
    longint unsigned u, a, a2, a3;
    bit neg;
    if (p > UNITY) p = UNITY;
    if (!cub) return p;
    u   = 2 * p;
    neg = u < UNITY;
    a   = neg ? (UNITY - u) : (u - UNITY);
    a2  = (a * a) >> GAIN_FRAC_BITS;
    a3  = (a2 * a) >> GAIN_FRAC_BITS;
    return neg ? ((UNITY - a3) >> 1) : ((UNITY + a3) >> 1);
  endfunction

  // advance the predicted state by one command, return the gains it shows
  function automatic gains_t next_gains(cmd_t c);
    longint unsigned len, inc, dt_l, k;
    gains_t g;
    g.stop  = '0;
    g.start = '0;
    case (c.mode)
      MODE_TICK: begin
        if (!paused_st && prog_st < UNITY) begin
          len  = (fade_len_st == 0) ? 1 : fade_len_st;
          dt_l = c.dt;
          inc  = (dt_l << GAIN_FRAC_BITS) / len;
          if (inc >= UNITY - prog_st) begin
            // fade ends, outgoing voice goes silent and roles swap
            if (out_loaded_st) g.stop[out_voice_st] = 1'b1;
            out_voice_st  = ~out_voice_st;
            base_st       = UNITY;
            out_loaded_st = in_loaded_st;
            in_loaded_st  = 1'b0;
            prog_st       = UNITY;
            n_fade_done++;
          end else begin
            prog_st += inc;
          end
        end
      end
      MODE_PLAY: begin
        if (c.slope == 0) begin
          // instant switch onto the outgoing voice
          if (out_loaded_st) g.stop[out_voice_st] = 1'b1;
          if (in_loaded_st) g.stop[!out_voice_st] = 1'b1;
          in_loaded_st  = 1'b0;
          out_loaded_st = 1'b1;
          prog_st       = UNITY;
          base_st       = UNITY;
          g.start[out_voice_st] = 1'b1;
          n_instant++;
        end else begin
          if (prog_st < UNITY) begin
            // cut into a running fade, keep its curve value as base gain
            if (out_loaded_st) g.stop[out_voice_st] = 1'b1;
            base_st       = fade_curve(prog_st, cubic_st);
            out_loaded_st = in_loaded_st;
            out_voice_st  = ~out_voice_st;
            n_fade_cut++;
          end else begin
            base_st = UNITY;
          end
          in_loaded_st = 1'b1;
          prog_st      = 0;
          fade_len_st  = c.slope;
          cubic_st     = c.cubic;
          g.start[!out_voice_st] = 1'b1;
        end
      end
      MODE_PAUSE: paused_st = c.pause_on;
      default: ;
    endcase
    if (prog_st < UNITY) begin
      k    = fade_curve(prog_st, cubic_st);
      g.ig = GAIN_W'(k);
      g.og = GAIN_W'(((UNITY - k) * base_st) >> GAIN_FRAC_BITS);
    end else begin
      g.ig = '0;
      g.og = GAIN_W'(UNITY);
    end
    g.voice  = out_voice_st;
    g.fading = prog_st < UNITY;
    g.paused = paused_st;
    return g;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_cnt < 40)
      $display("ERROR @%0t result %0d: %s got %0d want %0d", $time, checked_cnt, what, got,
               want);
    err_cnt++;
  endtask

  task automatic queue_cmd(input logic [MODE_W-1:0] m, input logic [DT_W-1:0] d,
                           input logic [SLOPE_W-1:0] s, input logic cub, input logic pon);
    cmd_t c;
    c = '{mode: m, dt: d, slope: s, cubic: cub, pause_on: pon};
    cmd_q.push_back(c);
    if (m != MODE_UNUSED) n_real++;
  endtask

  // wait until every queued command went through and every result came back
  task automatic wait_for_drain();
    while (!(cmd_q.size() == 0 && !in_valid_i && acc_cnt == checked_cnt))
      @(negedge clk_i);
  endtask

  function automatic logic [SLOPE_W-1:0] pick_fade_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom;
    if (r == 1) return '1;
    if (r < 4) return $urandom_range(1, 16);
    return $urandom_range(500, 400000);
  endfunction

  // cycle counter and run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("two_voice_crossfade_gain_top: mismatch");
      $finish;
    end
  end

  // command driver, predicts on every input transfer
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic take, nxt_valid;
    cmd_t cur_cmd;
    int   gap_left, gap_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
      gap_pct  = 20;
    end else begin
      take      = in_valid_i && !in_stall_o;
      nxt_valid = in_valid_i && !take;
      if (cycle_cnt % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 20;
          default: gap_pct = 60;
        endcase
      end
      if (take) begin
        gains_due_q.push_back(next_gains(cur_cmd));
        acc_cnt++;
        if (!calm && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 7);
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          nxt_valid = 1'b1;
          mode_i        <= cur_cmd.mode;
          dt_us_i       <= cur_cmd.dt;
          slope_us_i    <= cur_cmd.slope;
          cubic_curve_i <= cur_cmd.cubic;
          pause_on_i    <= cur_cmd.pause_on;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // result monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin : watch
    gains_t want;
    int     stall_left, stall_pct;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      stall_pct  = 20;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (gains_due_q.size() == 0) begin
          report_mismatch("unexpected result, voice", outgoing_voice_o, 0);
        end else begin
          want = gains_due_q.pop_front();
          if (outgoing_voice_o !== want.voice)
            report_mismatch("outgoing_voice", outgoing_voice_o, want.voice);
          if (outgoing_gain_o !== want.og)
            report_mismatch("outgoing_gain", outgoing_gain_o, want.og);
          if (incoming_gain_o !== want.ig)
            report_mismatch("incoming_gain", incoming_gain_o, want.ig);
          if (stop_mask_o !== want.stop)
            report_mismatch("stop_mask", stop_mask_o, want.stop);
          if (start_mask_o !== want.start)
            report_mismatch("start_mask", start_mask_o, want.start);
          if (fading_o !== want.fading)
            report_mismatch("fading", fading_o, want.fading);
          if (is_paused_o !== want.paused)
            report_mismatch("is_paused", is_paused_o, want.paused);
          checked_cnt++;
        end
      end
      if (cycle_cnt % 256 == 128) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 6);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // stimulus and end of run
  initial begin : stim
    int                 pick, ticks, n_dir;
    logic [SLOPE_W-1:0] slope;
    longint unsigned    step;
    bit                 drained_mid;
    drained_mid = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle tick, instant switches, fades, pause, curve extremes
    queue_cmd(MODE_TICK, '1, '0, 1'b0, 1'b0);
    queue_cmd(MODE_PAUSE, '0, '1, 1'b1, 1'b0);
    queue_cmd(MODE_PLAY, '0, '0, 1'b0, 1'b1);
    queue_cmd(MODE_PLAY, '0, '1, 1'b1, 1'b0);
    queue_cmd(MODE_TICK, '0, '0, 1'b0, 1'b0);
    queue_cmd(MODE_TICK, '1, '0, 1'b0, 1'b0);
    queue_cmd(MODE_PAUSE, '0, '0, 1'b0, 1'b1);
    queue_cmd(MODE_TICK, 20'd5000, '0, 1'b0, 1'b0);
    queue_cmd(MODE_PLAY, '0, 24'd1000, 1'b0, 1'b0);
    queue_cmd(MODE_PAUSE, '1, '0, 1'b1, 1'b0);
    queue_cmd(MODE_TICK, 20'd1, '0, 1'b0, 1'b0);
    queue_cmd(MODE_UNUSED, $urandom, $urandom, 1'b1, 1'b1);
    queue_cmd(MODE_TICK, '1, '0, 1'b0, 1'b0);
    queue_cmd(MODE_TICK, 20'd10, '0, 1'b0, 1'b0);
    queue_cmd(MODE_PLAY, '0, 24'd1, 1'b1, 1'b0);
    queue_cmd(MODE_TICK, 20'd1, '0, 1'b0, 1'b0);
    queue_cmd(MODE_PLAY, '0, 24'd4000, 1'b1, 1'b0);
    queue_cmd(MODE_TICK, 20'd2000, '0, 1'b0, 1'b0);
    queue_cmd(MODE_PLAY, '0, '0, 1'b1, 1'b0);
    queue_cmd(MODE_PLAY, '0, 24'd2, 1'b0, 1'b0);
    queue_cmd(MODE_TICK, 20'd1, '0, 1'b0, 1'b0);
    queue_cmd(MODE_PLAY, '0, 24'd3, 1'b1, 1'b0);
    queue_cmd(MODE_TICK, '0, '1, 1'b1, 1'b1);
    queue_cmd(MODE_PLAY, '1, '0, 1'b0, 1'b0);
    queue_cmd(MODE_UNUSED, '0, '0, 1'b0, 1'b0);
    n_dir = n_real;
    wait_for_drain();

    // random: mostly a play followed by ticks that carry the fade along
    while (n_real < n_dir + RANDOM_CMDS) begin
      if (!drained_mid && n_real >= n_dir + RANDOM_CMDS / 2) begin
        wait_for_drain();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        slope = pick_fade_len();
        queue_cmd(MODE_PLAY, $urandom, slope, $urandom, $urandom);
        ticks = $urandom_range(1, 12);
        for (int i = 0; i < ticks; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            queue_cmd(MODE_PAUSE, $urandom, $urandom, $urandom, 1'b1);
            queue_cmd(MODE_TICK, $urandom, $urandom, $urandom, $urandom);
            queue_cmd(MODE_PAUSE, $urandom, $urandom, $urandom, 1'b0);
          end
          step = slope / $urandom_range(1, 10);
          if ($urandom_range(0, 9) == 0) step = $urandom;
          if (step > DT_MAX) step = DT_MAX;
          queue_cmd(MODE_TICK, step, $urandom, $urandom, $urandom);
        end
      end else if (pick < 78) begin
        queue_cmd(MODE_PLAY, $urandom, '0, $urandom, $urandom);
      end else if (pick < 88) begin
        queue_cmd(MODE_PAUSE, $urandom, $urandom, $urandom, $urandom);
        queue_cmd(MODE_TICK, $urandom, $urandom, $urandom, $urandom);
        queue_cmd(MODE_PAUSE, $urandom, $urandom, $urandom, $urandom_range(0, 3) != 0);
      end else begin
        // noise, any mode and any field values
        slope = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
        queue_cmd($urandom_range(0, 3), $urandom, slope, $urandom, $urandom);
      end
    end

    // last stretch runs at full rate on both sides
    while (cmd_q.size() > CALM_CMDS) @(negedge clk_i);
    calm = 1'b1;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d commands and %0d checked results", acc_cnt, checked_cnt);
    $display("fades: %0d finished, %0d cut by a new track, %0d instant switches",
             n_fade_done, n_fade_cut, n_instant);
    if (err_cnt == 0 && gains_due_q.size() == 0) begin
      $display("two_voice_crossfade_gain_top: match");
    end else begin
      $display("two_voice_crossfade_gain_top: mismatch");
    end
    $finish;
  end

endmodule

>>> two_voice_crossfade_gain_top.f
rtl/core/tvcg_pkg.sv
rtl/core/tvcg_div.sv
rtl/core/two_voice_crossfade_gain_top.sv
bench/two_voice_crossfade_gain_top_tb.sv
